### src/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### src/bsa_pkg.sv
// Types, constants and helper functions of the buddy superblock allocator.
`default_nettype none
package bsa_pkg;

   localparam int POOL_LOG     = 16;
   localparam int MIN_LOG      = 5;
   localparam int HEADER_BYTES = 16;
   localparam int OFF_W        = 16;
   localparam int SIZE_W       = 16;
   localparam int NEED_W       = SIZE_W + 1;

   localparam int SLOT_W = POOL_LOG - MIN_LOG;
   localparam int SLOTS  = 1 << SLOT_W;
   localparam int PTR_W  = SLOT_W + 1;
   localparam int KCLS   = POOL_LOG + 2;
   localparam int ICLS   = POOL_LOG + 1;
   localparam int K_W    = $clog2(KCLS);
   localparam int NHEADS = KCLS * ICLS;
   localparam int HEAD_AW = $clog2(NHEADS);
   localparam int CLR_N  = (SLOTS > NHEADS) ? SLOTS : NHEADS;
   localparam int CLR_W  = $clog2(CLR_N);

   localparam logic [PTR_W-1:0]  NIL      = PTR_W'(SLOTS);
   localparam logic [K_W-1:0]    TOP_K    = K_W'(POOL_LOG + 1);
   localparam logic [K_W-1:0]    NO_CLASS = '1;
   localparam logic [SIZE_W-1:0] MAX_REQ_RESET = SIZE_W'(65504);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
   localparam logic [1:0] STAT_NO_REGION = 2'd2;

   typedef struct packed {
      logic              opcode;
      logic [SIZE_W-1:0] request_size;
      logic [OFF_W-1:0]  user_offset;
   } bsa_req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] granted_offset;
   } bsa_rsp_type;

   typedef struct packed {
      logic             free;
      logic [K_W-1:0]   k;
      logic [PTR_W-1:0] prev;
      logic [PTR_W-1:0] next;
   } bsa_hdr_type;

   localparam int HDR_W = $bits(bsa_hdr_type);

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      bsa_hdr_type       wdata;
      logic [SLOT_W-1:0] raddr;
   } bsa_hdr_port_type;

   typedef struct packed {
      logic               we;
      logic [HEAD_AW-1:0] waddr;
      logic [PTR_W-1:0]   wdata;
      logic [HEAD_AW-1:0] raddr;
   } bsa_head_port_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_A_SCAN, S_A_HEAD, S_A_HEADW, S_A_HDR, S_A_SPLIT, S_A_NEXT,
      S_F_RD, S_F_CHK, S_F_LOOP, S_F_BUD, S_F_MRG, S_F_INS,
      S_R_P, S_R_PW, S_R_N, S_R_NW,
      S_I_HEAD, S_I_HDW, S_I_PW,
      S_DONE
   } bsa_state_type;

   // Lowest set bit of a class bitmap, all ones when empty.
   function automatic logic [K_W-1:0] low_bit(input logic [ICLS-1:0] bm);
      logic [K_W-1:0] r;
      r = NO_CLASS;
      for (int b = ICLS - 1; b >= 0; b--) begin
         if (bm[b]) r = K_W'(b);
      end
      return r;
   endfunction

   // Number of significant bits of a value.
   function automatic logic [K_W-1:0] bit_len(input logic [NEED_W-1:0] v);
      logic [K_W-1:0] r;
      r = '0;
      for (int b = 0; b < NEED_W; b++) begin
         if (v[b]) r = K_W'(b + 1);
      end
      return r;
   endfunction

   // Class index of a region that starts at slot idx with size class k.
   function automatic logic [K_W-1:0] cls_i(input logic [SLOT_W-1:0] idx,
                                            input logic [K_W-1:0] k);
      logic [K_W-1:0] lb;
      logic [K_W-1:0] km1;
      lb  = '1;
      km1 = k - K_W'(1);
      for (int b = SLOT_W - 1; b >= 0; b--) begin
         if (idx[b]) lb = K_W'(b + MIN_LOG);
      end
      if (k == '0) return '0;
      if (lb > km1) return km1;
      return lb;
   endfunction

   function automatic logic [HEAD_AW-1:0] head_addr(input logic [K_W-1:0] k,
                                                    input logic [K_W-1:0] i);
      return HEAD_AW'(int'(k) * ICLS + int'(i));
   endfunction

endpackage
`default_nettype wire

### src/bsa_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module bsa_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 30
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### src/bsa_seq.sv
// Sequencer that walks the region headers and free lists for each item.
`default_nettype none
module bsa_seq import bsa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire bsa_req_type       req_item,
   input  wire logic [SIZE_W-1:0] max_request,
   output logic                   busy,
   output logic                   done,
   output bsa_rsp_type            result,
   output bsa_hdr_port_type       hdr_port,
   input  wire bsa_hdr_type       hdr_rdata,
   output bsa_head_port_type      head_port,
   input  wire logic [PTR_W-1:0]  head_rdata
);
   bsa_state_type state_ff, state_in, ret_ff, ret_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [K_W-1:0]    j_ff, j_in, scan_ff, scan_in, best_k_ff, best_k_in, best_i_ff, best_i_in;
   logic [SLOT_W-1:0] idx_ff, idx_in, b_ff, b_in;
   logic [K_W-1:0]    k_ff, k_in, i_ff, i_in, bk_ff, bk_in;
   logic [PTR_W-1:0]  rem_prev_ff, rem_prev_in, rem_next_ff, rem_next_in;
   logic [K_W-1:0]    rem_k_ff, rem_k_in, rem_i_ff, rem_i_in;
   logic [SLOT_W-1:0] ins_idx_ff, ins_idx_in;
   logic [K_W-1:0]    ins_k_ff, ins_k_in;
   logic [PTR_W-1:0]  ins_h_ff, ins_h_in;
   logic              q0_v_ff, q0_v_in, q1_v_ff, q1_v_in;
   logic [SLOT_W-1:0] q0_idx_ff, q0_idx_in, q1_idx_ff, q1_idx_in;
   logic [K_W-1:0]    q0_k_ff, q0_k_in, q1_k_ff, q1_k_in;
   logic [1:0]        status_ff, status_in;
   logic [OFF_W-1:0]  grant_ff, grant_in;
   logic [ICLS-1:0]   bmp_ff [KCLS];

   logic              accept;
   logic [NEED_W-1:0] need;
   logic [K_W-1:0]    j_raw, j_acc;
   logic              too_large;
   logic [OFF_W:0]    off_sub;
   logic              free_ok;
   logic [SLOT_W-1:0] free_idx;
   logic [K_W-1:0]    bm_sel;
   logic [ICLS-1:0]   bm_cur;
   logic [K_W-1:0]    scan_lb;
   logic [K_W-1:0]    i_cur;
   logic [SLOT_W-1:0] b_calc;
   logic              loop_stop;
   logic              bud_bad;
   logic [K_W-1:0]    bud_cls;
   logic [K_W-1:0]    hdr_cls;
   logic [K_W-1:0]    ins_cls;
   logic [HEAD_AW-1:0] ins_s;
   logic [SLOT_W-1:0] step_j, step_i, a_idx, lo_idx, hi_idx;
   logic              split_hi;
   bsa_hdr_type       hdr_empty;

   assign accept    = start && (state_ff == S_IDLE);
   assign need      = {1'b0, req_item.request_size} + NEED_W'(HEADER_BYTES - 1);
   assign j_raw     = bit_len(need);
   assign j_acc     = (j_raw < K_W'(MIN_LOG)) ? K_W'(MIN_LOG) : j_raw;
   assign too_large = req_item.request_size > max_request;
   assign off_sub   = {1'b0, req_item.user_offset} - (OFF_W + 1)'(HEADER_BYTES);
   assign free_ok   = !off_sub[OFF_W] && (off_sub[MIN_LOG-1:0] == '0);
   assign free_idx  = off_sub[MIN_LOG +: SLOT_W];

   assign bm_cur  = bmp_ff[bm_sel];
   assign scan_lb = low_bit(bm_cur);

   assign i_cur     = cls_i(idx_ff, k_ff);
   assign b_calc    = idx_ff ^ (SLOT_W'(1) << (i_cur - K_W'(MIN_LOG)));
   assign loop_stop = ((idx_ff == '0) && (k_ff == TOP_K)) || (i_cur < K_W'(MIN_LOG))
                      || (i_cur >= K_W'(POOL_LOG));
   assign bud_cls   = cls_i(b_ff, hdr_rdata.k);
   assign bud_bad   = (hdr_rdata.k == '0) || !hdr_rdata.free || (bud_cls != i_ff)
                      || (hdr_rdata.k > K_W'(POOL_LOG));
   assign hdr_cls   = cls_i(idx_ff, hdr_rdata.k);
   assign ins_cls   = cls_i(ins_idx_ff, ins_k_ff);
   assign ins_s     = head_addr(ins_k_ff, ins_cls);

   assign step_j   = SLOT_W'(1) << (j_ff - K_W'(MIN_LOG));
   assign step_i   = SLOT_W'(1) << (i_ff - K_W'(MIN_LOG));
   assign a_idx    = idx_ff + step_j - step_i;
   assign split_hi = i_ff > j_ff;
   assign lo_idx   = (b_ff < idx_ff) ? b_ff : idx_ff;
   assign hi_idx   = (b_ff < idx_ff) ? idx_ff : b_ff;

   assign hdr_empty = '{free: 1'b0, k: '0, prev: NIL, next: NIL};

   always_comb begin
      case (state_ff)
         S_R_P:   bm_sel = rem_k_ff;
         S_I_HDW: bm_sel = ins_k_ff;
         S_A_SCAN: bm_sel = scan_ff;
         default: bm_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < KCLS; n++) begin
            bmp_ff[n] <= (n == int'(TOP_K)) ? (ICLS'(1) << POOL_LOG) : '0;
         end
      end else if ((state_ff == S_R_P) && rem_prev_ff[SLOT_W] && rem_next_ff[SLOT_W]) begin
         bmp_ff[bm_sel] <= bm_cur & ~(ICLS'(1) << rem_i_ff);
      end else if (state_ff == S_I_HDW) begin
         bmp_ff[bm_sel] <= bm_cur | (ICLS'(1) << ins_cls);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      j_ff        <= j_in;
      scan_ff     <= scan_in;
      best_k_ff   <= best_k_in;
      best_i_ff   <= best_i_in;
      idx_ff      <= idx_in;
      b_ff        <= b_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      bk_ff       <= bk_in;
      rem_prev_ff <= rem_prev_in;
      rem_next_ff <= rem_next_in;
      rem_k_ff    <= rem_k_in;
      rem_i_ff    <= rem_i_in;
      ins_idx_ff  <= ins_idx_in;
      ins_k_ff    <= ins_k_in;
      ins_h_ff    <= ins_h_in;
      q0_v_ff     <= q0_v_in;
      q1_v_ff     <= q1_v_in;
      q0_idx_ff   <= q0_idx_in;
      q1_idx_ff   <= q1_idx_in;
      q0_k_ff     <= q0_k_in;
      q1_k_ff     <= q1_k_in;
      status_ff   <= status_in;
      grant_ff    <= grant_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == CLR_W'(CLR_N - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_item.opcode == OP_FREE) begin
                  state_in = free_ok ? S_F_RD : S_DONE;
               end else if (too_large || (j_acc >= TOP_K)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_A_SCAN;
               end
            end
         end
         S_A_SCAN: begin
            if (scan_ff == TOP_K) state_in = S_A_HEAD;
         end
         S_A_HEAD:  state_in = (best_i_ff >= K_W'(ICLS)) ? S_DONE : S_A_HEADW;
         S_A_HEADW: state_in = head_rdata[SLOT_W] ? S_DONE : S_A_HDR;
         S_A_HDR:   state_in = S_R_P;
         S_A_SPLIT: state_in = S_A_NEXT;
         S_A_NEXT:  state_in = (q0_v_ff || q1_v_ff) ? S_I_HEAD : S_DONE;
         S_F_RD:    state_in = S_F_CHK;
         S_F_CHK: begin
            state_in = ((hdr_rdata.k == '0) || hdr_rdata.free) ? S_DONE : S_F_LOOP;
         end
         S_F_LOOP:  state_in = loop_stop ? S_F_INS : S_F_BUD;
         S_F_BUD:   state_in = bud_bad ? S_F_INS : S_R_P;
         S_F_MRG:   state_in = S_F_LOOP;
         S_F_INS:   state_in = S_I_HEAD;
         S_R_P:     state_in = rem_prev_ff[SLOT_W] ? S_R_N : S_R_PW;
         S_R_PW:    state_in = S_R_N;
         S_R_N:     state_in = rem_next_ff[SLOT_W] ? ret_ff : S_R_NW;
         S_R_NW:    state_in = ret_ff;
         S_I_HEAD:  state_in = S_I_HDW;
         S_I_HDW:   state_in = head_rdata[SLOT_W] ? ret_ff : S_I_PW;
         S_I_PW:    state_in = ret_ff;
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Working registers.
   always_comb begin
      clr_in      = clr_ff;
      ret_in      = ret_ff;
      j_in        = j_ff;
      scan_in     = scan_ff;
      best_k_in   = best_k_ff;
      best_i_in   = best_i_ff;
      idx_in      = idx_ff;
      b_in        = b_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      bk_in       = bk_ff;
      rem_prev_in = rem_prev_ff;
      rem_next_in = rem_next_ff;
      rem_k_in    = rem_k_ff;
      rem_i_in    = rem_i_ff;
      ins_idx_in  = ins_idx_ff;
      ins_k_in    = ins_k_ff;
      ins_h_in    = ins_h_ff;
      q0_v_in     = q0_v_ff;
      q1_v_in     = q1_v_ff;
      q0_idx_in   = q0_idx_ff;
      q1_idx_in   = q1_idx_ff;
      q0_k_in     = q0_k_ff;
      q1_k_in     = q1_k_ff;
      status_in   = status_ff;
      grant_in    = grant_ff;
      case (state_ff)
         S_CLEAR: clr_in = clr_ff + CLR_W'(1);
         S_IDLE: begin
            status_in = STAT_OK;
            grant_in  = '0;
            idx_in    = free_idx;
            j_in      = j_acc;
            scan_in   = j_acc + K_W'(1);
            best_i_in = NO_CLASS;
            best_k_in = '0;
            if (req_item.opcode == OP_ALLOC) begin
               if (too_large) status_in = STAT_TOO_LARGE;
               else if (j_acc >= TOP_K) status_in = STAT_NO_REGION;
            end
         end
         S_A_SCAN: begin
            if ((bm_cur != '0) && (scan_lb < best_i_ff)) begin
               best_i_in = scan_lb;
               best_k_in = scan_ff;
            end
            scan_in = scan_ff + K_W'(1);
         end
         S_A_HEAD: begin
            if (best_i_ff >= K_W'(ICLS)) status_in = STAT_NO_REGION;
         end
         S_A_HEADW: begin
            if (head_rdata[SLOT_W]) status_in = STAT_NO_REGION;
            idx_in = head_rdata[SLOT_W-1:0];
         end
         S_A_HDR: begin
            k_in        = hdr_rdata.k;
            i_in        = hdr_cls;
            rem_prev_in = hdr_rdata.prev;
            rem_next_in = hdr_rdata.next;
            rem_k_in    = hdr_rdata.k;
            rem_i_in    = hdr_cls;
            ret_in      = S_A_SPLIT;
         end
         S_A_SPLIT: begin
            if (split_hi) begin
               grant_in  = {idx_ff, MIN_LOG'(0)} + OFF_W'(HEADER_BYTES);
               q0_v_in   = 1'b1;
               q0_idx_in = idx_ff + step_j;
               q0_k_in   = i_ff;
               q1_v_in   = k_ff != (i_ff + K_W'(1));
               q1_idx_in = idx_ff + step_i;
               q1_k_in   = k_ff;
            end else begin
               grant_in  = {a_idx, MIN_LOG'(0)} + OFF_W'(HEADER_BYTES);
               q0_v_in   = j_ff > i_ff;
               q0_idx_in = idx_ff;
               q0_k_in   = j_ff;
               q1_v_in   = (j_ff + K_W'(1)) < k_ff;
               q1_idx_in = a_idx + step_j;
               q1_k_in   = k_ff;
            end
         end
         S_A_NEXT: begin
            ret_in = S_A_NEXT;
            if (q0_v_ff) begin
               ins_idx_in = q0_idx_ff;
               ins_k_in   = q0_k_ff;
               q0_v_in    = 1'b0;
            end else begin
               ins_idx_in = q1_idx_ff;
               ins_k_in   = q1_k_ff;
               q1_v_in    = 1'b0;
            end
         end
         S_F_CHK: k_in = hdr_rdata.k;
         S_F_LOOP: begin
            i_in = i_cur;
            b_in = b_calc;
         end
         S_F_BUD: begin
            bk_in       = hdr_rdata.k;
            rem_prev_in = hdr_rdata.prev;
            rem_next_in = hdr_rdata.next;
            rem_k_in    = hdr_rdata.k;
            rem_i_in    = i_ff;
            ret_in      = S_F_MRG;
         end
         S_F_MRG: begin
            idx_in = lo_idx;
            k_in   = bk_ff + K_W'(1);
         end
         S_F_INS: begin
            ins_idx_in = idx_ff;
            ins_k_in   = k_ff;
            ret_in     = S_DONE;
         end
         S_I_HDW: ins_h_in = head_rdata;
         default: ;
      endcase
   end

   // Memory ports and status outputs.
   always_comb begin
      hdr_port  = '0;
      head_port = '0;
      busy      = state_ff != S_IDLE;
      done      = state_ff == S_DONE;
      case (state_ff)
         S_CLEAR: begin
            hdr_port.we    = int'(clr_ff) < SLOTS;
            hdr_port.waddr = clr_ff[SLOT_W-1:0];
            hdr_port.wdata = hdr_empty;
            if (clr_ff == '0) begin
               hdr_port.wdata.free = 1'b1;
               hdr_port.wdata.k    = TOP_K;
            end
            head_port.we    = int'(clr_ff) < NHEADS;
            head_port.waddr = clr_ff[HEAD_AW-1:0];
            head_port.wdata = (clr_ff[HEAD_AW-1:0] == head_addr(TOP_K, K_W'(POOL_LOG)))
                              ? PTR_W'(0) : NIL;
         end
         S_A_HEAD:  head_port.raddr = head_addr(best_k_ff, best_i_ff);
         S_A_HEADW: hdr_port.raddr = head_rdata[SLOT_W-1:0];
         S_A_SPLIT: begin
            hdr_port.we      = 1'b1;
            hdr_port.waddr   = split_hi ? idx_ff : a_idx;
            hdr_port.wdata   = hdr_empty;
            hdr_port.wdata.k = j_ff + K_W'(1);
         end
         S_F_RD:   hdr_port.raddr = idx_ff;
         S_F_LOOP: hdr_port.raddr = b_calc;
         S_F_MRG: begin
            hdr_port.we    = 1'b1;
            hdr_port.waddr = hi_idx;
            hdr_port.wdata = hdr_empty;
         end
         S_R_P: begin
            hdr_port.raddr  = rem_prev_ff[SLOT_W-1:0];
            head_port.we    = rem_prev_ff[SLOT_W];
            head_port.waddr = head_addr(rem_k_ff, rem_i_ff);
            head_port.wdata = rem_next_ff;
         end
         S_R_PW: begin
            hdr_port.we         = 1'b1;
            hdr_port.waddr      = rem_prev_ff[SLOT_W-1:0];
            hdr_port.wdata      = hdr_rdata;
            hdr_port.wdata.next = rem_next_ff;
         end
         S_R_N: hdr_port.raddr = rem_next_ff[SLOT_W-1:0];
         S_R_NW: begin
            hdr_port.we         = 1'b1;
            hdr_port.waddr      = rem_next_ff[SLOT_W-1:0];
            hdr_port.wdata      = hdr_rdata;
            hdr_port.wdata.prev = rem_prev_ff;
         end
         S_I_HEAD: head_port.raddr = ins_s;
         S_I_HDW: begin
            hdr_port.we         = 1'b1;
            hdr_port.waddr      = ins_idx_ff;
            hdr_port.wdata      = hdr_empty;
            hdr_port.wdata.free = 1'b1;
            hdr_port.wdata.k    = ins_k_ff;
            hdr_port.wdata.next = head_rdata;
            hdr_port.raddr      = head_rdata[SLOT_W-1:0];
            head_port.we        = 1'b1;
            head_port.waddr     = ins_s;
            head_port.wdata     = {1'b0, ins_idx_ff};
         end
         S_I_PW: begin
            hdr_port.we         = 1'b1;
            hdr_port.waddr      = ins_h_ff[SLOT_W-1:0];
            hdr_port.wdata      = hdr_rdata;
            hdr_port.wdata.prev = {1'b0, ins_idx_ff};
         end
         default: ;
      endcase
   end

   assign result = '{status: status_ff, granted_offset: grant_ff};
endmodule
`default_nettype wire

### src/buddy_superblock_allocator_core.sv
// An allocate runs the class bitmap scan, the list unlink and up to two list inserts;
// a free runs a buddy check and merge per level through the one header memory, then a
// list insert. One item at a time; the result strobe is registered from the sequencer's
// last step and comes in the cycle after it. After reset the block clears the header
// and list head memories, one entry a cycle, with busy high.
`default_nettype none
`include "assert_macros.svh"
module buddy_superblock_allocator_core import bsa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire bsa_req_type       req_item,
   output logic                   rsp_valid,
   output bsa_rsp_type            rsp_item,
   input  wire logic              csr_we,
   input  wire logic [SIZE_W-1:0] csr_wdata
);
   logic [SIZE_W-1:0] max_request_ff;
   logic              rsp_valid_ff;
   bsa_rsp_type       rsp_item_ff;
   logic              seq_done;
   bsa_rsp_type       seq_result;
   bsa_hdr_port_type  hdr_port;
   bsa_hdr_type       hdr_rdata;
   bsa_head_port_type head_port;
   logic [PTR_W-1:0]  head_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_request_ff <= MAX_REQ_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            max_request_ff <= csr_wdata;
         end
         rsp_valid_ff <= seq_done;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) begin
         rsp_item_ff <= seq_result;
      end
   end

   bsa_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_item    (req_item),
      .max_request (max_request_ff),
      .busy        (busy),
      .done        (seq_done),
      .result      (seq_result),
      .hdr_port    (hdr_port),
      .hdr_rdata   (hdr_rdata),
      .head_port   (head_port),
      .head_rdata  (head_rdata)
   );

   bsa_ram #(.DEPTH(SLOTS), .WIDTH(HDR_W)) u_hdr_ram (
      .clock (clock),
      .we    (hdr_port.we),
      .waddr (hdr_port.waddr),
      .wdata (hdr_port.wdata),
      .raddr (hdr_port.raddr),
      .rdata (hdr_rdata)
   );

   bsa_ram #(.DEPTH(NHEADS), .WIDTH(PTR_W)) u_head_ram (
      .clock (clock),
      .we    (head_port.we),
      .waddr (head_port.waddr),
      .wdata (head_port.wdata),
      .raddr (head_port.raddr),
      .rdata (head_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "back-to-back result strobes")
   `ASSERT_ALWAYS(a_fail_no_grant, clock, reset, !rsp_valid_ff || (rsp_item_ff.status == STAT_OK) || (rsp_item_ff.granted_offset == '0), "failed item carries an offset")
   `ASSERT_ALWAYS(a_grant_align, clock, reset, !rsp_valid_ff || (rsp_item_ff.granted_offset == '0) || (rsp_item_ff.granted_offset[MIN_LOG-1:0] == MIN_LOG'(HEADER_BYTES)), "granted offset misaligned")
endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the buddy superblock allocator core.
`default_nettype none
module testbench import bsa_pkg::*;;

   localparam int NSLOT = 2048;
   localparam int NONE  = 2048;
   localparam int TOPK  = 17;
   localparam int NI    = 17;
   localparam int NK    = 18;
   localparam int CYCLE_LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   bsa_req_type req_item = '0;
   logic rsp_valid;
   bsa_rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [SIZE_W-1:0] csr_wdata = '0;

   buddy_superblock_allocator_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow allocator state.
   bit        slot_free [NSLOT];
   int        slot_k [NSLOT];
   int        slot_prev [NSLOT];
   int        slot_next [NSLOT];
   int        class_head [NK*NI];
   bit [NI-1:0] class_map [NK];
   int        limit_bytes;

   bsa_req_type pending_items[$];
   bsa_rsp_type expected_rsps[$];
   int        live_grants[$];
   int        errors = 0;
   int        cycles = 0;
   int        checked = 0;
   int        burst_left = 0;
   int        gap_left = 0;

   function automatic int lowest(input longint v);
      for (int b = 0; b < 64; b++) if (v[b]) return b;
      return 64;
   endfunction

   function automatic int region_class(input int idx);
      int lb;
      if (slot_k[idx] == 0) return 0;
      lb = lowest(longint'(idx) << MIN_LOG);
      return (lb < slot_k[idx] - 1) ? lb : slot_k[idx] - 1;
   endfunction

   function automatic void link_region(input int idx);
      int k;
      int i;
      int s;
      k = slot_k[idx];
      i = region_class(idx);
      if (k >= NK || i >= NI) return;
      s = k * NI + i;
      slot_prev[idx] = NONE;
      slot_next[idx] = class_head[s];
      if (class_head[s] < NSLOT) slot_prev[class_head[s]] = idx;
      class_head[s] = idx;
      class_map[k][i] = 1'b1;
   endfunction

   function automatic void unlink_region(input int idx);
      int k;
      int i;
      int s;
      int p;
      int n;
      k = slot_k[idx];
      i = region_class(idx);
      p = slot_prev[idx];
      n = slot_next[idx];
      if (k >= NK || i >= NI) return;
      s = k * NI + i;
      if (p < NSLOT) slot_next[p] = n;
      else class_head[s] = n;
      if (n < NSLOT) slot_prev[n] = p;
      if (class_head[s] >= NSLOT) class_map[k][i] = 1'b0;
   endfunction

   function automatic void release_piece(input longint off, input int k);
      int idx;
      idx = int'(off >> MIN_LOG) & (NSLOT - 1);
      slot_free[idx] = 1'b1;
      slot_k[idx] = k;
      link_region(idx);
   endfunction

   function automatic void shadow_reset();
      for (int n = 0; n < NSLOT; n++) begin
         slot_free[n] = 0; slot_k[n] = 0; slot_prev[n] = NONE; slot_next[n] = NONE;
      end
      for (int n = 0; n < NK*NI; n++) class_head[n] = NONE;
      for (int n = 0; n < NK; n++) class_map[n] = '0;
      limit_bytes = 65504;
      slot_free[0] = 1'b1;
      slot_k[0] = TOPK;
      link_region(0);
   endfunction

   function automatic int carve_region(input int size, output longint off_out);
      longint need;
      longint off;
      longint a;
      int j;
      int best_i;
      int best_k;
      int idx;
      int old_k;
      int old_i;
      int aidx;
      need = longint'(size) + HEADER_BYTES - 1;
      j = 0;
      while (j < 63 && (need >> (j + 1)) != 0) j++;
      j++;
      if (j < MIN_LOG) j = MIN_LOG;
      best_i = 64;
      best_k = 0;
      for (int k = j + 1; k < NK; k++) begin
         if (class_map[k] != 0 && lowest(longint'(class_map[k])) < best_i) begin
            best_i = lowest(longint'(class_map[k]));
            best_k = k;
         end
      end
      if (best_i >= NI) return 2;
      idx = class_head[best_k * NI + best_i];
      if (idx >= NSLOT) return 2;
      unlink_region(idx);
      old_k = slot_k[idx];
      old_i = region_class(idx);
      off = longint'(idx) << MIN_LOG;
      if (old_i > j) begin
         slot_free[idx] = 0;
         slot_k[idx] = j + 1;
         release_piece(off + (longint'(1) << j), old_i);
         if (old_k != old_i + 1) release_piece(off + (longint'(1) << old_i), old_k);
         off_out = off;
         return 0;
      end
      a = off + (longint'(1) << j) - (longint'(1) << old_i);
      aidx = int'(a >> MIN_LOG) & (NSLOT - 1);
      slot_free[aidx] = 0;
      slot_k[aidx] = j + 1;
      if (j > old_i) begin
         slot_k[idx] = j;
         link_region(idx);
      end
      if (j + 1 < old_k) release_piece(a + (longint'(1) << j), old_k);
      off_out = a;
      return 0;
   endfunction

   function automatic void return_region(input int user);
      longint off;
      longint boff;
      int idx;
      int b;
      int i;
      int k;
      int bk;
      int lo;
      int hi;
      if (user < HEADER_BYTES) return;
      off = longint'(user) - HEADER_BYTES;
      if ((off & ((1 << MIN_LOG) - 1)) != 0) return;
      if ((off >> MIN_LOG) >= NSLOT) return;
      idx = int'(off >> MIN_LOG);
      if (slot_k[idx] == 0 || slot_free[idx]) return;
      slot_free[idx] = 1'b1;
      forever begin
         k = slot_k[idx];
         i = region_class(idx);
         off = longint'(idx) << MIN_LOG;
         if (off == 0 && k == TOPK) break;
         boff = off ^ (longint'(1) << i);
         if ((boff >> MIN_LOG) >= NSLOT) break;
         b = int'(boff >> MIN_LOG);
         if (b == idx || slot_k[b] == 0 || !slot_free[b]) break;
         if (region_class(b) != i || slot_k[b] > POOL_LOG) break;
         unlink_region(b);
         bk = slot_k[b];
         lo = (b < idx) ? b : idx;
         hi = (b < idx) ? idx : b;
         slot_k[hi] = 0; slot_free[hi] = 0;
         slot_k[lo] = bk + 1; slot_free[lo] = 1'b1;
         idx = lo;
      end
      link_region(idx);
   endfunction

   function automatic bsa_rsp_type predict_rsp(input bsa_req_type it);
      bsa_rsp_type r;
      longint off;
      int st;
      r = '0;
      if (it.opcode == OP_ALLOC) begin
         if (int'(it.request_size) > limit_bytes) begin
            r.status = STAT_TOO_LARGE;
         end else begin
            st = carve_region(int'(it.request_size), off);
            if (st == 0) r.granted_offset = OFF_W'(off + HEADER_BYTES);
            else r.status = STAT_NO_REGION;
         end
      end else begin
         return_region(int'(it.user_offset));
      end
      return r;
   endfunction

   // Driver: bursts of items separated by random gaps.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.push_back(predict_rsp(req_item));
         end
         if (start && busy) begin
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_items.size() > 0) begin
            start <= 1'b1;
            req_item <= pending_items.pop_front();
            if (burst_left == 0) begin
               burst_left <= $urandom_range(20, 1);
               gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 0);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, rsp_item);
            errors = errors + 1;
         end else begin
            bsa_rsp_type e;
            e = expected_rsps.pop_front();
            checked <= checked + 1;
            if (e.status != rsp_item.status)
               begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, e.status, rsp_item.status);
               errors = errors + 1;
            end
            if (e.granted_offset != rsp_item.granted_offset) begin
               $display("%0t: offset mismatch, expected %0h, actual %0h",
                        $time, e.granted_offset, rsp_item.granted_offset);
               errors = errors + 1;
            end
            if (rsp_item.status == STAT_OK && rsp_item.granted_offset != 0 &&
                e.status == STAT_OK)
               live_grants.push_back(int'(e.granted_offset));
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic bsa_req_type alloc_item(input int size);
      bsa_req_type it;
      it = '0;
      it.opcode = OP_ALLOC;
      it.request_size = SIZE_W'(size);
      it.user_offset = OFF_W'($urandom);
      return it;
   endfunction

   function automatic bsa_req_type free_item(input int user);
      bsa_req_type it;
      it = '0;
      it.opcode = OP_FREE;
      it.request_size = SIZE_W'($urandom);
      it.user_offset = OFF_W'(user);
      return it;
   endfunction

   function automatic int random_size();
      int r;
      r = $urandom_range(99, 0);
      if (r < 60) return $urandom_range(200, 0);
      if (r < 85) return $urandom_range(2000, 0);
      if (r < 97) return $urandom_range(16000, 0);
      return $urandom_range(65535, 0);
   endfunction

   task automatic drain();
      while (pending_items.size() > 0 || start || busy || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_limit(input int v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= SIZE_W'(v);
      @(posedge clock);
      csr_we <= 1'b0;
      limit_bytes = v;
   endtask

   task automatic random_phase(input int count);
      int pick;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99, 0);
         if (r < 50 || live_grants.size() == 0) begin
            pending_items.push_back(alloc_item(random_size()));
         end else if (r < 92) begin
            pick = $urandom_range(live_grants.size() - 1, 0);
            pending_items.push_back(free_item(live_grants[pick]));
            live_grants.delete(pick);
         end else begin
            pending_items.push_back(free_item($urandom_range(65535, 0)));
         end
         if (pending_items.size() > 8) drain();
      end
      drain();
   endtask

   initial begin
      shadow_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // Directed: size extremes, whole pool, bad frees, double free.
      pending_items.push_back(alloc_item(0));
      pending_items.push_back(alloc_item(65535));
      pending_items.push_back(alloc_item(65504));
      pending_items.push_back(alloc_item(65505));
      pending_items.push_back(free_item(0));
      pending_items.push_back(free_item(15));
      pending_items.push_back(free_item(17));
      pending_items.push_back(free_item(65535));
      pending_items.push_back(free_item(16));
      pending_items.push_back(free_item(16));
      pending_items.push_back(alloc_item(16));
      pending_items.push_back(alloc_item(17));
      pending_items.push_back(alloc_item(32752));
      pending_items.push_back(alloc_item(1));
      pending_items.push_back(alloc_item(1000));
      drain();
      while (live_grants.size() > 0)
         pending_items.push_back(free_item(live_grants.pop_front()));
      drain();
      write_limit(0);
      pending_items.push_back(alloc_item(0));
      pending_items.push_back(alloc_item(1));
      random_phase(60);
      write_limit(65535);
      random_phase(700);
      write_limit(500);
      random_phase(300);
      write_limit($urandom_range(65535, 0));
      random_phase(300);
      write_limit(65504);
      random_phase(300);
      while (live_grants.size() > 0)
         pending_items.push_back(free_item(live_grants.pop_front()));
      drain();
      $display("Checked %0d results over allocate and free sequences with several size limits.",
               checked);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
